@@ src/ptcs_pkg.sv @@
`timescale 1ns / 1ps

package ptcs_pkg;

  // Default depth of the result queue between the classifier and the output stage.
  localparam int unsigned FIFO_DEPTH = 4;

  // Kind of the chunk that is currently open.
  typedef enum logic [2:0] {
    KIND_IDLE     = 3'd0,
    KIND_FIRST    = 3'd1,
    KIND_LETTERS  = 3'd2,
    KIND_PUNCT    = 3'd3,
    KIND_SPACES   = 3'd4,
    KIND_CONTRACT = 3'd5
  } kind_e;

  // Decision for one incoming byte: does it continue the chunk, and what comes next.
  typedef struct packed {
    logic  cont;
    kind_e nk;
  } step_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       fin;
  } result_t;

  // Results produced by one accepted item, oldest in first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_pair_t;

  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NONE  = 8'h00;

  function automatic logic [7:0] to_low(input logic [7:0] b);
    to_low = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
               (b == CH_FF) || (b == CH_VT);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    logic [7:0] l;
    l = to_low(b);
    is_alpha = (l >= 8'h61 && l <= 8'h7A) || b[7];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    is_punct = !is_space(b) && !is_alpha(b) && !is_digit(b);
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = !is_alpha(b) && !is_digit(b) && (b != CH_LF) && (b != CH_CR);
  endfunction

  // Second letter of a two-letter contraction ('re 've 'll), or none.
  function automatic logic [7:0] second_of(input logic [7:0] lowered);
    case (lowered)
      8'h72:   second_of = 8'h65;
      8'h76:   second_of = 8'h65;
      8'h6C:   second_of = 8'h6C;
      default: second_of = CH_NONE;
    endcase
  endfunction

  // One-letter contraction tails: 's 't 'm 'd.
  function automatic logic is_single_tail(input logic [7:0] lowered);
    is_single_tail = (lowered == 8'h73) || (lowered == 8'h74) ||
                     (lowered == 8'h6D) || (lowered == 8'h64);
  endfunction

  // The open chunk is the single byte c; decide what byte b does to it.
  function automatic step_t after_first(input logic [7:0] c, input logic [7:0] b);
    step_t      r;
    logic [7:0] lb;
    lb     = to_low(b);
    r.cont = 1'b0;
    r.nk   = KIND_FIRST;
    if (is_alpha(c)) begin
      if (is_alpha(b)) begin
        r.cont = 1'b1;
        r.nk   = KIND_LETTERS;
      end
    end else if (is_digit(c)) begin
      r.cont = 1'b0;
    end else if (c == CH_APOS && second_of(lb) != CH_NONE) begin
      r.cont = 1'b1;
      r.nk   = KIND_CONTRACT;
    end else if (c == CH_APOS && is_single_tail(lb)) begin
      r.cont = 1'b1;
      r.nk   = KIND_IDLE;
    end else if (is_lead(c) && is_alpha(b)) begin
      r.cont = 1'b1;
      r.nk   = KIND_LETTERS;
    end else if (is_space(c)) begin
      if (c == CH_SPACE && is_punct(b)) begin
        r.cont = 1'b1;
        r.nk   = KIND_PUNCT;
      end else if (is_space(b)) begin
        r.cont = 1'b1;
        r.nk   = KIND_SPACES;
      end
    end else if (is_punct(b)) begin
      r.cont = 1'b1;
      r.nk   = KIND_PUNCT;
    end
    after_first = r;
  endfunction

endpackage

@@ src/ptcs_front.sv @@
`timescale 1ns / 1ps

module ptcs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_of_text_i,
  output ptcs_pkg::push_pair_t wr_o
);

  ptcs_pkg::kind_e kind_q, kind_d;
  logic            held_q, held_d;
  logic            fixed_q, fixed_d;
  logic            long_q, long_d;
  logic [7:0]      lead_q, lead_d;
  logic [7:0]      held_byte_q, held_byte_d;

  ptcs_pkg::step_t   step;
  ptcs_pkg::result_t rel_item;
  ptcs_pkg::result_t new_item;
  logic              accept;
  logic              rel_v;
  logic              rel_start;
  logic              hold;

  assign accept = push_i && !full_i;

  always_comb begin
    step.cont = 1'b0;
    step.nk   = ptcs_pkg::KIND_FIRST;
    rel_v     = 1'b0;
    rel_start = 1'b0;
    if (kind_q == ptcs_pkg::KIND_SPACES && held_q) begin
      // A held whitespace byte goes out now; it starts a chunk only when it
      // is split off the end of a longer run.
      rel_v = 1'b1;
      if (ptcs_pkg::is_space(text_byte_i)) begin
        step.cont = 1'b1;
        step.nk   = ptcs_pkg::KIND_SPACES;
      end else begin
        rel_start = long_q;
        step      = ptcs_pkg::after_first(held_byte_q, text_byte_i);
      end
    end else begin
      case (kind_q)
        ptcs_pkg::KIND_FIRST: begin
          step = ptcs_pkg::after_first(lead_q, text_byte_i);
        end
        ptcs_pkg::KIND_LETTERS: begin
          step.cont = ptcs_pkg::is_alpha(text_byte_i);
          step.nk   = ptcs_pkg::KIND_LETTERS;
        end
        ptcs_pkg::KIND_PUNCT: begin
          step.cont = ptcs_pkg::is_punct(text_byte_i);
          step.nk   = ptcs_pkg::KIND_PUNCT;
        end
        ptcs_pkg::KIND_CONTRACT: begin
          if (fixed_q) begin
            if (ptcs_pkg::to_low(text_byte_i) == ptcs_pkg::second_of(lead_q)) begin
              step.cont = 1'b1;
              step.nk   = ptcs_pkg::KIND_IDLE;
            end else begin
              step.cont = ptcs_pkg::is_alpha(text_byte_i);
              step.nk   = ptcs_pkg::KIND_LETTERS;
            end
          end
        end
        default: begin
          step.cont = 1'b0;
        end
      endcase
    end
    if (!step.cont) begin
      step.nk = ptcs_pkg::KIND_FIRST;
    end
    hold = (step.nk == ptcs_pkg::KIND_SPACES) && !end_of_text_i;
  end

  always_comb begin
    rel_item.data  = held_byte_q;
    rel_item.start = rel_start;
    rel_item.fin   = 1'b0;
    new_item.data  = text_byte_i;
    new_item.start = !step.cont;
    new_item.fin   = end_of_text_i;

    wr_o.first  = rel_v ? rel_item : new_item;
    wr_o.second = new_item;
    wr_o.count  = accept ? ({1'b0, rel_v} + {1'b0, !hold}) : 2'd0;
  end

  always_comb begin
    kind_d      = kind_q;
    held_d      = held_q;
    fixed_d     = fixed_q;
    long_d      = long_q;
    lead_d      = lead_q;
    held_byte_d = held_byte_q;
    if (accept) begin
      held_d  = hold;
      fixed_d = 1'b0;
      long_d  = hold;
      if (hold) begin
        held_byte_d = text_byte_i;
        kind_d      = ptcs_pkg::KIND_SPACES;
      end else if (end_of_text_i) begin
        kind_d = ptcs_pkg::KIND_IDLE;
      end else begin
        kind_d = step.nk;
        if (step.nk == ptcs_pkg::KIND_FIRST) begin
          lead_d = text_byte_i;
        end else if (step.nk == ptcs_pkg::KIND_CONTRACT) begin
          lead_d  = ptcs_pkg::to_low(text_byte_i);
          fixed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= ptcs_pkg::KIND_IDLE;
      held_q  <= 1'b0;
      fixed_q <= 1'b0;
      long_q  <= 1'b0;
    end else begin
      kind_q  <= kind_d;
      held_q  <= held_d;
      fixed_q <= fixed_d;
      long_q  <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q      <= lead_d;
    held_byte_q <= held_byte_d;
  end

  a_held_in_spaces : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> kind_q == ptcs_pkg::KIND_SPACES)
    else $error("held byte outside a whitespace run");

  a_silent_means_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && wr_o.count == 2'd0) |=> held_q)
    else $error("accepted byte produced no result and was not held");

  a_held_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && held_q) |-> wr_o.count != 2'd0)
    else $error("held byte not released on the next byte");

endmodule

@@ src/ptcs_fifo.sv @@
`timescale 1ns / 1ps

module ptcs_fifo #(
  parameter int unsigned Depth = ptcs_pkg::FIFO_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptcs_pkg::push_pair_t wr_i,
  output logic                 full_o,
  input  logic                 rd_i,
  output logic                 valid_o,
  output ptcs_pkg::result_t    rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullLvl = CntW'(Depth - 1);

  ptcs_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wp_q, wp_d, wp1;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic [CntW-1:0]   count_q, count_d;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  // Up to two entries can enter per cycle, so full leaves room for a pair.
  assign full_o  = count_q >= FullLvl;
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rp_q];
  assign wp1     = inc(wp_q);

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    if (wr_i.count == 2'd1) begin
      wp_d = wp1;
    end else if (wr_i.count == 2'd2) begin
      wp_d = inc(wp1);
    end
    if (rd_i) begin
      rp_d = inc(rp_q);
    end
    count_d = count_q + CntW'(wr_i.count) - CntW'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) begin
      mem_q[wp_q] <= wr_i.first;
    end
    if (wr_i.count == 2'd2) begin
      mem_q[wp1] <= wr_i.second;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.count != 2'd0) |-> !full_o)
    else $error("result queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> count_q != '0)
    else $error("result queue read while empty");

endmodule

@@ src/ptcs_back.sv @@
`timescale 1ns / 1ps

module ptcs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ptcs_pkg::result_t q_data_i,
  output logic              q_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ptcs_pkg::result_t out_o
);

  logic              valid_q, valid_d;
  ptcs_pkg::result_t data_q;
  logic              take;

  assign take    = pop_i && valid_q;
  assign q_rd_o  = q_valid_i && (!valid_q || take);
  assign valid_d = q_rd_o || (valid_q && !take);
  assign empty_o = !valid_q;
  assign out_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      data_q <= q_data_i;
    end
  end

endmodule

@@ src/pretokenizer_chunk_splitter.sv @@
`timescale 1ns / 1ps

// Pre-tokenizer chunk splitter. Text enters one byte per transaction (push/full)
// with end_of_text_i on its last byte, and every byte leaves unchanged and in
// order (empty/pop) with chunk_start_o marking the first byte of each pre-token
// chunk: apostrophe contractions, letter runs with an optional lead byte, single
// digits, punctuation runs with an optional leading space, and whitespace runs
// whose last space is split off before a non-space byte. A whitespace byte inside
// a run is held back until the next byte decides where it belongs; the final byte
// flushes it and returns the splitter to idle for the next text. A new byte is
// accepted every cycle while full is low: the classifier decides each byte in
// the cycle it arrives and writes zero, one or two results into a small result
// queue, and an output register presents the oldest result. full rises when
// fewer than two queue slots are free, so with pop held high the stream runs at
// one byte per cycle. A released result is written into the queue and then
// passes through the output register; when a transaction releases two results,
// the second replaces the first in the output register as the first is popped.

module pretokenizer_chunk_splitter #(
  parameter int unsigned FifoDepth = ptcs_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       chunk_start_o,
  output logic       final_byte_o
);

  ptcs_pkg::push_pair_t wr;
  ptcs_pkg::result_t    q_data;
  ptcs_pkg::result_t    out_item;
  logic                 q_valid;
  logic                 q_rd;

  // Classifier: holds the chunk state and decides the flag of each byte.
  ptcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .wr_o          (wr)
  );

  // Result queue that takes a released byte and the new byte in the same cycle.
  ptcs_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .full_o  (full),
    .rd_i    (q_rd),
    .valid_o (q_valid),
    .rdata_o (q_data)
  );

  // Output register facing the consumer.
  ptcs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_item)
  );

  assign out_byte_o    = out_item.data;
  assign chunk_start_o = out_item.start;
  assign final_byte_o  = out_item.fin;

endmodule
